// File: hdl/pdr_pkg.sv
// pdr_pkg: shared constants, types and the channel word decoder for the
// downmix and 24 kHz resampler. No dependencies.
`default_nettype none
package pdr_pkg;

    localparam int MAX_CHANNELS      = 8;
    localparam int MAX_PACKET_FRAMES = 4096;
    localparam int OUT_RATE          = 24000;
    localparam int MAX_OUT           = 3;

    localparam int WORD_W  = 32;
    localparam int FR_W    = 13;
    localparam int POS_W   = 12;
    localparam int IDX_W   = 14;
    localparam int RATE_W  = 19;
    localparam int NCH_W   = 4;
    localparam int CH_W    = $clog2(MAX_CHANNELS);
    localparam int F24_W   = 27;
    localparam int ACC_W   = 35;
    localparam int SUM_W   = 36;
    localparam int NUM_W   = 49;
    localparam int Q_W     = 16;
    localparam int K_W     = 4;
    localparam int CNT_W   = 2;
    localparam int SMP_W   = 16;
    localparam int CFG_W   = 19;
    localparam int CIDX_W  = 2;

    typedef enum logic [1:0] {
        FMT_FLOAT32,
        FMT_PCM16,
        FMT_PCM32,
        FMT_NONE
    } t_fmt;

    typedef enum logic [CIDX_W-1:0] {
        REG_FORMAT,
        REG_CHANNELS,
        REG_RATE,
        REG_SPARE
    } t_reg;

    typedef struct packed {
        logic load;
        logic setup;
        logic acc_step;
        logic scale;
        logic div_step;
        logic round;
        logic emit;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic zero;
        logic active;
        logic ch_last;
        logic div_last;
        logic emit_ok;
        logic run_end;
        logic out_free;
    } t_stat;

    // Q2.30 value of one channel word
    function automatic logic signed [31:0] decode_word(input t_fmt fmt,
                                                       input logic [31:0] w);
        logic [7:0]  e;
        logic [22:0] m;
        logic [23:0] full;
        logic [30:0] mag;
        logic [4:0]  rs;
        logic [23:0] q;
        logic [23:0] rem;
        logic [23:0] half;
        logic [32:0] s_abs;
        logic signed [31:0] res;
        e     = w[30:23];
        m     = w[22:0];
        full  = {1'b1, m};
        mag   = '0;
        rs    = '0;
        q     = '0;
        rem   = '0;
        half  = '0;
        s_abs = '0;
        res   = '0;
        unique case (fmt)
            FMT_FLOAT32: begin
                if (e == 8'hFF && m != 23'd0) begin
                    mag = '0;
                end else if (e >= 8'd127) begin
                    mag = 31'h4000_0000;
                end else if (e == 8'd0) begin
                    mag = '0;
                end else if (e >= 8'd120) begin
                    mag = 31'(full) << (e - 8'd120);
                end else if (e < 8'd96) begin
                    mag = '0;
                end else begin
                    rs   = 5'(8'd120 - e);
                    q    = full >> rs;
                    rem  = full & ((24'd1 << rs) - 24'd1);
                    half = 24'd1 << (rs - 5'd1);
                    if (rem > half || (rem == half && q[0])) begin
                        q = q + 24'd1;
                    end
                    mag = 31'(q);
                end
                res = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            FMT_PCM16: begin
                res = $signed({w[15], w[15:0], 15'b0});
            end
            FMT_PCM32: begin
                s_abs = w[31] ? (33'h1_0000_0000 - {1'b0, w}) : {1'b0, w};
                mag   = 31'(s_abs[32:1] + 32'(s_abs[1] & s_abs[0]));
                res   = w[31] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            end
            FMT_NONE: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: hdl/pcm_downmix_resample_24k.sv
// pcm_downmix_resample_24k: top level, joins pdr_ctrl and pdr_dp.
// Depends on pdr_pkg, pdr_ctrl, pdr_dp.
//
//  channel  direction  handshake             payload
//  in       request    i_valid / o_stall     i_chan0..7_word, i_packet_frames, i_packet_silent
//  out      request    o_valid / i_stall     o_mono_sample, o_run_last, o_packet_last
//  cfg      write      i_cfg_we              i_cfg_index, i_cfg_data
//
// A frame that makes no sample (silent, zero frames, zero rate or channels)
// goes straight to commit; else its N channels are decoded one a cycle, a
// 16-step quotient divider runs, then M (0..3) output requests follow.
// o_stall is high from acceptance until the frame's commit cycle.
// A stalled output holds; the next request waits for it to be taken.
// Synchronous active-low reset; no clearing pass.
`default_nettype none
module pcm_downmix_resample_24k (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pdr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [pdr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan0_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan1_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan2_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan3_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan4_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan5_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan6_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan7_word,
    input  wire logic [pdr_pkg::FR_W-1:0]      i_packet_frames,
    input  wire logic                          i_packet_silent,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic signed [pdr_pkg::SMP_W-1:0]   o_mono_sample,
    output logic                               o_run_last,
    output logic                               o_packet_last
);

    pdr_pkg::t_cmd  cmd;
    pdr_pkg::t_stat stat;

    pdr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    pdr_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_chan0_word    (i_chan0_word),
        .i_chan1_word    (i_chan1_word),
        .i_chan2_word    (i_chan2_word),
        .i_chan3_word    (i_chan3_word),
        .i_chan4_word    (i_chan4_word),
        .i_chan5_word    (i_chan5_word),
        .i_chan6_word    (i_chan6_word),
        .i_chan7_word    (i_chan7_word),
        .i_packet_frames (i_packet_frames),
        .i_packet_silent (i_packet_silent),
        .i_stall         (i_stall),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .o_valid         (o_valid),
        .o_mono_sample   (o_mono_sample),
        .o_run_last      (o_run_last),
        .o_packet_last   (o_packet_last)
    );

endmodule
`default_nettype wire

// File: hdl/pdr_ctrl.sv
// pdr_ctrl: sequencer for one source frame: setup, channel accumulate,
// scale, divide, round, emit, commit. Depends on pdr_pkg.
`default_nettype none
module pdr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    input  pdr_pkg::t_stat     i_stat,
    output pdr_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_ACCUM,
        S_SCALE,
        S_DIVIDE,
        S_ROUND,
        S_EMIT,
        S_COMMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.load = i_valid;
                if (i_valid) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_ACCUM;
            end
            S_ACCUM: begin
                if (i_stat.zero || !i_stat.active) begin
                    n_state = S_COMMIT;
                end else begin
                    o_cmd.acc_step = 1'b1;
                    if (i_stat.ch_last) begin
                        n_state = S_SCALE;
                    end
                end
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_DIVIDE;
            end
            S_DIVIDE: begin
                o_cmd.div_step = 1'b1;
                if (i_stat.div_last) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                if (!i_stat.emit_ok) begin
                    n_state = S_COMMIT;
                end else if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.run_end) begin
                        n_state = S_COMMIT;
                    end
                end
            end
            S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_stall = (r_state != S_IDLE);

endmodule
`default_nettype wire

// File: hdl/pdr_dp.sv
// pdr_dp: datapath: configuration, frame capture, serial channel decode and
// sum, 16-step quotient divider, output indexing and the output request
// register. Depends on pdr_pkg.
`default_nettype none
module pdr_dp (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [pdr_pkg::CIDX_W-1:0]    i_cfg_index,
    input  wire logic [pdr_pkg::CFG_W-1:0]     i_cfg_data,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan0_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan1_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan2_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan3_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan4_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan5_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan6_word,
    input  wire logic [pdr_pkg::WORD_W-1:0]    i_chan7_word,
    input  wire logic [pdr_pkg::FR_W-1:0]      i_packet_frames,
    input  wire logic                          i_packet_silent,
    input  wire logic                          i_stall,
    input  pdr_pkg::t_cmd                      i_cmd,
    output pdr_pkg::t_stat                     o_stat,
    output logic                               o_valid,
    output logic signed [pdr_pkg::SMP_W-1:0]   o_mono_sample,
    output logic                               o_run_last,
    output logic                               o_packet_last
);

    pdr_pkg::t_fmt                     r_fmt;
    logic [pdr_pkg::NCH_W-1:0]         r_cfg_nch;
    logic [pdr_pkg::RATE_W-1:0]        r_rate;

    logic [pdr_pkg::WORD_W-1:0]        r_word [pdr_pkg::MAX_CHANNELS];
    logic [pdr_pkg::FR_W-1:0]          r_frames;
    logic                              r_silent;

    logic [pdr_pkg::POS_W-1:0]         r_pos;
    logic [pdr_pkg::IDX_W-1:0]         r_idx;

    logic [pdr_pkg::NCH_W-1:0]         r_nch;
    logic [pdr_pkg::F24_W-1:0]         r_f24;
    logic [pdr_pkg::F24_W-1:0]         r_p24;
    logic [pdr_pkg::ACC_W-1:0]         r_acc;
    logic                              r_last;
    logic                              r_zero;
    logic                              r_active;

    logic [pdr_pkg::CH_W-1:0]          r_ch;
    logic signed [pdr_pkg::SUM_W-1:0]  r_sum;
    logic                              r_neg;
    logic [pdr_pkg::NUM_W-1:0]         r_rem;
    logic [pdr_pkg::Q_W-1:0]           r_q;
    logic [pdr_pkg::K_W-1:0]           r_k;
    logic signed [pdr_pkg::SMP_W-1:0]  r_sample;
    logic [pdr_pkg::CNT_W-1:0]         r_cnt;

    logic [pdr_pkg::FR_W-1:0]          fs;
    logic [pdr_pkg::NCH_W-1:0]         nch_sat;
    logic [pdr_pkg::FR_W-1:0]          pos_inc;
    logic signed [31:0]                dec;
    logic [pdr_pkg::SUM_W-2:0]         abs_sum;
    logic [pdr_pkg::NUM_W-1:0]         trial;
    logic [33:0]                       div_d;
    logic [34:0]                       rem2;
    logic                              up;
    logic [pdr_pkg::Q_W:0]             qq;
    logic [14:0]                       mag;
    logic [pdr_pkg::ACC_W-1:0]         acc_r1;
    logic [pdr_pkg::ACC_W-1:0]         acc_r2;
    logic                              next_ok;

    always_comb begin
        if (r_frames > pdr_pkg::FR_W'(pdr_pkg::MAX_PACKET_FRAMES)) begin
            fs = pdr_pkg::FR_W'(pdr_pkg::MAX_PACKET_FRAMES);
        end else begin
            fs = r_frames;
        end
        nch_sat = (r_cfg_nch > pdr_pkg::NCH_W'(pdr_pkg::MAX_CHANNELS))
                  ? pdr_pkg::NCH_W'(pdr_pkg::MAX_CHANNELS) : r_cfg_nch;
        pos_inc = pdr_pkg::FR_W'(r_pos) + pdr_pkg::FR_W'(1);
        dec     = pdr_pkg::decode_word(r_fmt, r_word[r_ch]);
        abs_sum = r_sum[pdr_pkg::SUM_W-1] ? (pdr_pkg::SUM_W-1)'(-r_sum)
                                          : (pdr_pkg::SUM_W-1)'(r_sum);
        trial   = pdr_pkg::NUM_W'(r_nch) << (6'd30 + 6'(r_k));
        div_d   = {r_nch, 30'b0};
        rem2    = {r_rem[33:0], 1'b0};
        up      = (rem2 > {1'b0, div_d}) || (rem2 == {1'b0, div_d} && r_q[0]);
        qq      = {1'b0, r_q} + (pdr_pkg::Q_W+1)'(up);
        mag     = (qq > 17'd32767) ? 15'h7FFF : qq[14:0];
        acc_r1  = r_acc + pdr_pkg::ACC_W'(r_rate);
        acc_r2  = acc_r1 + pdr_pkg::ACC_W'(r_rate);
        next_ok = (r_cnt < pdr_pkg::CNT_W'(pdr_pkg::MAX_OUT - 1))
                  && (acc_r2 <= pdr_pkg::ACC_W'(r_f24))
                  && (acc_r1 < pdr_pkg::ACC_W'(r_p24));
    end

    always_comb begin
        o_stat          = '0;
        o_stat.zero     = r_zero;
        o_stat.active   = r_active;
        o_stat.ch_last  = ({1'b0, r_ch} == (r_nch - pdr_pkg::NCH_W'(1)));
        o_stat.div_last = (r_k == '0);
        o_stat.emit_ok  = ((r_idx == '0) || (acc_r1 <= pdr_pkg::ACC_W'(r_f24)))
                          && (r_acc < pdr_pkg::ACC_W'(r_p24));
        o_stat.run_end  = !next_ok;
        o_stat.out_free = !o_valid || !i_stall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt     <= pdr_pkg::FMT_PCM16;
            r_cfg_nch <= pdr_pkg::NCH_W'(2);
            r_rate    <= pdr_pkg::RATE_W'(48000);
        end else if (i_cfg_we) begin
            if (i_cfg_index == pdr_pkg::REG_FORMAT) begin
                r_fmt <= pdr_pkg::t_fmt'(i_cfg_data[1:0]);
            end else if (i_cfg_index == pdr_pkg::REG_CHANNELS) begin
                r_cfg_nch <= i_cfg_data[pdr_pkg::NCH_W-1:0];
            end else if (i_cfg_index == pdr_pkg::REG_RATE) begin
                r_rate <= i_cfg_data[pdr_pkg::RATE_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_word[0] <= i_chan0_word;
            r_word[1] <= i_chan1_word;
            r_word[2] <= i_chan2_word;
            r_word[3] <= i_chan3_word;
            r_word[4] <= i_chan4_word;
            r_word[5] <= i_chan5_word;
            r_word[6] <= i_chan6_word;
            r_word[7] <= i_chan7_word;
            r_frames  <= i_packet_frames;
            r_silent  <= i_packet_silent;
        end
        if (i_cmd.setup) begin
            r_nch    <= nch_sat;
            r_f24    <= pdr_pkg::F24_W'(fs) * pdr_pkg::F24_W'(pdr_pkg::OUT_RATE);
            r_p24    <= pdr_pkg::F24_W'(pos_inc) * pdr_pkg::F24_W'(pdr_pkg::OUT_RATE);
            r_acc    <= pdr_pkg::ACC_W'(r_idx) * pdr_pkg::ACC_W'(r_rate);
            r_last   <= (pos_inc >= fs);
            r_zero   <= (r_frames == '0);
            r_active <= !r_silent && (r_rate != '0) && (nch_sat != '0);
            r_sum    <= '0;
            r_ch     <= '0;
        end
        if (i_cmd.acc_step) begin
            r_sum <= r_sum + pdr_pkg::SUM_W'(dec);
            r_ch  <= r_ch + pdr_pkg::CH_W'(1);
        end
        if (i_cmd.scale) begin
            r_neg <= r_sum[pdr_pkg::SUM_W-1];
            r_rem <= (pdr_pkg::NUM_W'(abs_sum) << 15) - pdr_pkg::NUM_W'(abs_sum);
            r_q   <= '0;
            r_k   <= pdr_pkg::K_W'(pdr_pkg::Q_W - 1);
        end
        if (i_cmd.div_step) begin
            if (r_rem >= trial) begin
                r_rem    <= r_rem - trial;
                r_q[r_k] <= 1'b1;
            end
            r_k <= r_k - pdr_pkg::K_W'(1);
        end
        if (i_cmd.round) begin
            r_sample <= r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
            r_cnt    <= '0;
        end
        if (i_cmd.emit) begin
            r_acc         <= acc_r1;
            r_cnt         <= r_cnt + pdr_pkg::CNT_W'(1);
            o_mono_sample <= r_sample;
            o_run_last    <= !next_ok;
            o_packet_last <= (acc_r2 > pdr_pkg::ACC_W'(r_f24));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_idx   <= '0;
            o_valid <= 1'b0;
        end else begin
            if (i_cmd.emit) begin
                o_valid <= 1'b1;
                r_idx   <= r_idx + pdr_pkg::IDX_W'(1);
            end else if (o_valid && !i_stall) begin
                o_valid <= 1'b0;
            end
            if (i_cmd.commit) begin
                if (r_zero || r_last) begin
                    r_pos <= '0;
                    r_idx <= '0;
                end else begin
                    r_pos <= r_pos + pdr_pkg::POS_W'(1);
                end
            end
        end
    end

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (!o_valid || !i_stall))
        else $error("request issued over a held output");

    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.round |-> (r_rem < pdr_pkg::NUM_W'(div_d)))
        else $error("divider remainder not below divisor");

    a_emit_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_cnt < pdr_pkg::CNT_W'(pdr_pkg::MAX_OUT)))
        else $error("too many requests for one frame");

    a_no_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> (o_mono_sample != 16'sh8000))
        else $error("sample outside symmetric range");

endmodule
`default_nettype wire
